// File: hdl/byte_stack_with_invert_and_purge_unit_assert.svh
// Assertion macros for the byte stack unit checker.
// Needs signals clk and rst in the scope of each use.
`ifndef BYTE_STACK_WITH_INVERT_AND_PURGE_UNIT_ASSERT_SVH
`define BYTE_STACK_WITH_INVERT_AND_PURGE_UNIT_ASSERT_SVH

// same-cycle implication
`define BSTK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSTK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bstk_pkg.sv
// Shared constants and types for the byte stack unit.
// No dependencies.
package bstk_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;
  localparam int DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INVERT = 3'd2,
    CMD_PURGE  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_INV_RLO,
    S_INV_RHI,
    S_INV_WLO,
    S_INV_WHI,
    S_PRG_RD,
    S_PRG_CHK,
    S_TOP_RD,
    S_TOP_WAIT,
    S_DONE
  } state_t;

endpackage

// File: hdl/bstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/byte_stack_with_invert_and_purge_unit.sv
// Byte stack unit: push, pop, invert, purge-equal and clear on a LIFO in RAM.
// Depends on bstk_pkg and bstk_ram.
//
//   channel | dir | handshake         | fields
//   --------+-----+-------------------+------------------------------------------
//   in      | in  | in_valid/in_stall | cmd, data_value
//   out     | out | out_valid/out_stall | popped_value, removed_count, push_refused,
//           |     |                   | top_value, entry_count, is_empty
//
// One word at a time (n = entries held): pop with n > 1 reads the new top; invert
//   with n >= 2 swaps pairs from both ends (read lo, read hi, write lo, write hi);
//   purge reads each entry and writes back the unequal ones. Both walks then read
//   the new top unless none is left; the single RAM read port sets their steps.
// Synchronous reset empties the stack; RAM contents are not cleared.
// in_stall is high while a word is in work; a stalled result holds the next one.
module byte_stack_with_invert_and_purge_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bstk_pkg::CMD_W-1:0]  cmd,
  input  logic [bstk_pkg::DATA_W-1:0] data_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bstk_pkg::DATA_W-1:0] popped_value,
  output logic [bstk_pkg::CNT_W-1:0]  removed_count,
  output logic                        push_refused,
  output logic [bstk_pkg::DATA_W-1:0] top_value,
  output logic [bstk_pkg::CNT_W-1:0]  entry_count,
  output logic                        is_empty
);
  import bstk_pkg::*;

  state_t state, state_next;

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] data_q;
  logic [CNT_W-1:0]  count, count_next;
  logic [DATA_W-1:0] top, top_next;
  logic [DATA_W-1:0] popped, popped_next;
  logic [CNT_W-1:0]  removed, removed_next;
  logic              refused, refused_next;
  logic [ADDR_W-1:0] lo, lo_next, hi, hi_next;
  logic [CNT_W-1:0]  rd_ptr, rd_ptr_next, wr_ptr, wr_ptr_next;
  logic [DATA_W-1:0] hold_lo, hold_lo_next;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0]  cnt_m1, cnt_m2, rd_inc, wr_inc;
  logic              keep, prg_last, inv_more, accept, load;

  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign rd_inc   = rd_ptr + CNT_W'(1);
  assign keep     = (ram_rdata != data_q);
  assign wr_inc   = wr_ptr + CNT_W'(keep);
  assign prg_last = (rd_inc >= count);
  assign inv_more = (({1'b0, lo} + (ADDR_W + 1)'(2)) < {1'b0, hi});
  assign accept   = in_valid && !in_stall;
  assign load     = (state == S_DONE) && (!out_valid || !out_stall);

  bstk_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_POP: begin
            if (count > CNT_W'(1)) state_next = S_POP_WAIT;
            else state_next = S_DONE;
          end
          CMD_INVERT: begin
            if (count > CNT_W'(1)) state_next = S_INV_RLO;
            else state_next = S_DONE;
          end
          CMD_PURGE: begin
            if (count != '0) state_next = S_PRG_RD;
            else state_next = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_POP_WAIT: state_next = S_DONE;
      S_INV_RLO:  state_next = S_INV_RHI;
      S_INV_RHI:  state_next = S_INV_WLO;
      S_INV_WLO:  state_next = S_INV_WHI;
      S_INV_WHI: begin
        if (inv_more) state_next = S_INV_RLO;
        else state_next = S_TOP_RD;
      end
      S_PRG_RD: state_next = S_PRG_CHK;
      S_PRG_CHK: begin
        if (prg_last) state_next = S_TOP_RD;
        else state_next = S_PRG_RD;
      end
      S_TOP_RD: begin
        if (count == '0) state_next = S_DONE;
        else state_next = S_TOP_WAIT;
      end
      S_TOP_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    in_stall     = (state != S_IDLE);
    count_next   = count;
    top_next     = top;
    popped_next  = popped;
    removed_next = removed;
    refused_next = refused;
    lo_next      = lo;
    hi_next      = hi;
    rd_ptr_next  = rd_ptr;
    wr_ptr_next  = wr_ptr;
    hold_lo_next = hold_lo;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    case (state)
      S_IDLE: begin
        popped_next  = '0;
        removed_next = '0;
        refused_next = 1'b0;
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_PUSH: begin
            if (count < CNT_W'(DEPTH)) begin
              ram_we     = 1'b1;
              ram_waddr  = count[ADDR_W-1:0];
              ram_wdata  = data_q;
              count_next = count + CNT_W'(1);
              top_next   = data_q;
            end else begin
              refused_next = 1'b1;
            end
          end
          CMD_POP: begin
            if (count != '0) begin
              popped_next = top;
              count_next  = cnt_m1;
              if (count > CNT_W'(1)) begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m2[ADDR_W-1:0];
              end else begin
                top_next = '0;
              end
            end
          end
          CMD_INVERT: begin
            lo_next = '0;
            hi_next = cnt_m1[ADDR_W-1:0];
          end
          CMD_PURGE: begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
          end
          CMD_CLEAR: begin
            count_next = '0;
            top_next   = '0;
          end
          default: ;
        endcase
      end
      S_POP_WAIT: top_next = ram_rdata;
      S_INV_RLO: begin
        ram_re    = 1'b1;
        ram_raddr = lo;
      end
      S_INV_RHI: begin
        hold_lo_next = ram_rdata;
        ram_re       = 1'b1;
        ram_raddr    = hi;
      end
      S_INV_WLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = ram_rdata;
      end
      S_INV_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = hold_lo;
        lo_next   = lo + ADDR_W'(1);
        hi_next   = hi - ADDR_W'(1);
      end
      S_PRG_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rd_ptr[ADDR_W-1:0];
      end
      S_PRG_CHK: begin
        if (keep) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr[ADDR_W-1:0];
          ram_wdata = ram_rdata;
        end
        wr_ptr_next = wr_inc;
        rd_ptr_next = rd_inc;
        if (prg_last) begin
          count_next   = wr_inc;
          removed_next = count - wr_inc;
        end
      end
      S_TOP_RD: begin
        if (count == '0) begin
          top_next = '0;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_m1[ADDR_W-1:0];
        end
      end
      S_TOP_WAIT: top_next = ram_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      top   <= top_next;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      data_q <= data_value;
    end
    popped  <= popped_next;
    removed <= removed_next;
    refused <= refused_next;
    lo      <= lo_next;
    hi      <= hi_next;
    rd_ptr  <= rd_ptr_next;
    wr_ptr  <= wr_ptr_next;
    hold_lo <= hold_lo_next;
    if (load) begin
      popped_value  <= popped;
      removed_count <= removed;
      push_refused  <= refused;
      top_value     <= top;
      entry_count   <= count;
      is_empty      <= (count == '0);
    end
  end

endmodule

// File: hdl/bstk_chk.sv
// Port-level checker for the byte stack unit, bound to the top level.
// Depends on bstk_pkg and the assertion macro header.
`include "byte_stack_with_invert_and_purge_unit_assert.svh"

module bstk_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bstk_pkg::DATA_W-1:0] popped_value,
  input logic [bstk_pkg::CNT_W-1:0]  removed_count,
  input logic                        push_refused,
  input logic [bstk_pkg::DATA_W-1:0] top_value,
  input logic [bstk_pkg::CNT_W-1:0]  entry_count,
  input logic                        is_empty
);
  import bstk_pkg::*;

  `BSTK_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (entry_count == '0), "empty flag mismatch")
  `BSTK_ASSERT_NOW(a_empty_top, out_valid && is_empty, top_value == '0, "nonzero top on empty")
  `BSTK_ASSERT_NOW(a_refused_full, out_valid && push_refused, (entry_count == CNT_W'(DEPTH)) && (removed_count == '0) && (popped_value == '0), "refused push while not full")
  `BSTK_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(top_value) && $stable(entry_count), "stalled word changed")

endmodule

bind byte_stack_with_invert_and_purge_unit bstk_chk u_bstk_chk (.*);
